### src/frdf_pkg.sv
package frdf_pkg;

  // field widths of the header and result items
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned NUM_W     = 16;
  localparam int unsigned HOP_W     = 8;
  localparam int unsigned VERDICT_W = 2;

  // history sizing
  localparam int unsigned HISTORY_DEPTH = 5;
  localparam int unsigned NUMBER_BITS   = 16;
  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);

  // header kind codes
  localparam logic KIND_LOCAL = 1'b0;
  localparam logic KIND_RADIO = 1'b1;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OWN_ECHO  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd2;

  // lookup and record request to the history
  typedef struct packed {
    logic                   push;
    logic [ADDR_W-1:0]      origin;
    logic [NUMBER_BITS-1:0] number;
  } hist_req_t;

endpackage

### src/frdf_in_if.sv
interface frdf_in_if;
  import frdf_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] origin_address;
  logic [NUM_W-1:0]  message_number;
  logic [HOP_W-1:0]  hop_limit;

  modport source (
    output valid, kind, origin_address, message_number, hop_limit,
    input  ready
  );

  modport sink (
    input  valid, kind, origin_address, message_number, hop_limit,
    output ready
  );

endinterface

### src/frdf_out_if.sv
interface frdf_out_if;
  import frdf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 forward;
  logic [HOP_W-1:0]     forward_hop_limit;
  logic                 deliver;

  modport source (
    output valid, verdict, forward, forward_hop_limit, deliver,
    input  ready
  );

  modport sink (
    input  valid, verdict, forward, forward_hop_limit, deliver,
    output ready
  );

endinterface

### src/frdf_history.sv
module frdf_history (
  input  logic                clk,
  input  logic                rst,
  input  frdf_pkg::hist_req_t req,
  output logic                hit
);
  import frdf_pkg::*;

  localparam int unsigned CNT_W = SLOT_W + 1;

  logic [ADDR_W-1:0]      entry_origin [HISTORY_DEPTH];
  logic [NUMBER_BITS-1:0] entry_number [HISTORY_DEPTH];
  logic [FILL_W-1:0]      fill;
  logic [SLOT_W-1:0]      oldest;
  logic [FILL_W-1:0]      fill_next;
  logic [SLOT_W-1:0]      oldest_next;
  logic [SLOT_W-1:0]      write_slot;
  logic [CNT_W-1:0]       write_sum;
  logic                   full;

  // parallel compare against the live entries
  always_comb begin
    logic [CNT_W-1:0] offset;
    hit = 1'b0;
    for (int s = 0; s < HISTORY_DEPTH; s++) begin
      offset = CNT_W'(s) + CNT_W'(HISTORY_DEPTH) - CNT_W'(oldest);
      if (offset >= CNT_W'(HISTORY_DEPTH)) begin
        offset = offset - CNT_W'(HISTORY_DEPTH);
      end
      if ((offset < CNT_W'(fill)) && (entry_origin[s] == req.origin) &&
          (entry_number[s] == req.number)) begin
        hit = 1'b1;
      end
    end
  end

  // slot to write and ring pointer update
  assign full      = (fill == FILL_W'(HISTORY_DEPTH));
  assign write_sum = CNT_W'(oldest) + CNT_W'(fill);

  always_comb begin
    fill_next   = fill;
    oldest_next = oldest;
    if (!full) begin
      if (write_sum >= CNT_W'(HISTORY_DEPTH)) begin
        write_slot = SLOT_W'(write_sum - CNT_W'(HISTORY_DEPTH));
      end else begin
        write_slot = SLOT_W'(write_sum);
      end
      fill_next = fill + FILL_W'(1);
    end else begin
      write_slot = oldest;
      if (oldest == SLOT_W'(HISTORY_DEPTH - 1)) begin
        oldest_next = '0;
      end else begin
        oldest_next = oldest + SLOT_W'(1);
      end
    end
  end

  // fill count and oldest pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      oldest <= '0;
    end else if (req.push) begin
      fill   <= fill_next;
      oldest <= oldest_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (req.push) begin
      entry_origin[write_slot] <= req.origin;
      entry_number[write_slot] <= req.number;
    end
  end

endmodule

### src/flood_relay_duplicate_filter_top.sv
// channel  | role  | handshake     | payload
// header   | sink  | valid / ready | kind, origin_address, message_number, hop_limit
// result   | src   | valid / ready | verdict, forward, forward_hop_limit, deliver
// cfg      | write | cfg_write     | cfg_data -> own address
//
// one item per cycle sustained while the result is not stalled; each header is
// held in the input register, then history compare and update, then result register
// the history is checked and recorded in the same cycle, so back to back items see
// each other; rst clears the valid flags, the history fill and the ring pointer
// a stalled result holds the input register, which then accepts no new item
module flood_relay_duplicate_filter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [frdf_pkg::ADDR_W-1:0] cfg_data,
  frdf_in_if.sink                     header,
  frdf_out_if.source                  result
);
  import frdf_pkg::*;

  logic [ADDR_W-1:0]      own_address;
  logic                   s1_valid;
  logic                   s1_kind;
  logic [ADDR_W-1:0]      s1_origin;
  logic [NUMBER_BITS-1:0] s1_number;
  logic [HOP_W-1:0]       s1_hops;
  logic                   out_valid;
  logic [VERDICT_W-1:0]   out_verdict;
  logic                   out_forward;
  logic [HOP_W-1:0]       out_hops;
  logic                   out_deliver;
  logic                   advance;
  logic                   hit;
  hist_req_t              hist_req;
  logic [VERDICT_W-1:0]   verdict_next;
  logic                   forward_next;
  logic [HOP_W-1:0]       hops_next;
  logic                   deliver_next;

  // own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  // handshake
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign header.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (header.ready) begin
      s1_valid <= header.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (header.valid && header.ready) begin
      s1_kind   <= header.kind;
      s1_origin <= header.origin_address;
      s1_number <= header.message_number[NUMBER_BITS-1:0];
      s1_hops   <= header.hop_limit;
    end
  end

  // history lookup and record
  assign hist_req.origin = s1_origin;
  assign hist_req.number = s1_number;
  assign hist_req.push   = advance && (verdict_next == VERDICT_ACCEPT);

  frdf_history u_history (
    .clk (clk),
    .rst (rst),
    .req (hist_req),
    .hit (hit)
  );

  // verdict, echo check ahead of the duplicate check
  always_comb begin
    forward_next = 1'b0;
    hops_next    = '0;
    deliver_next = 1'b0;
    priority if ((s1_kind == KIND_RADIO) && (s1_origin == own_address)) begin
      verdict_next = VERDICT_OWN_ECHO;
    end else if ((s1_kind == KIND_RADIO) && hit) begin
      verdict_next = VERDICT_DUPLICATE;
    end else begin
      verdict_next = VERDICT_ACCEPT;
      deliver_next = 1'b1;
      if ((s1_kind == KIND_RADIO) && (s1_hops != '0)) begin
        forward_next = 1'b1;
        hops_next    = s1_hops - HOP_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict <= verdict_next;
      out_forward <= forward_next;
      out_hops    <= hops_next;
      out_deliver <= deliver_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.verdict           = out_verdict;
  assign result.forward           = out_forward;
  assign result.forward_hop_limit = out_hops;
  assign result.deliver           = out_deliver;

endmodule
